// File: hdl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg: shared types and constants
// Operation and result-kind codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package kvi_pkg;

    localparam int DEF_MAX_TRACKS = 16;
    localparam int DEF_MAX_KEYS   = 64;
    localparam int DEF_FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        OP_WRITE_KEY = 2'd0,
        OP_SET_COUNT = 2'd1,
        OP_SAMPLE    = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CASE_INTERP = 2'd0,
        CASE_EMPTY  = 2'd1,
        CASE_SINGLE = 2'd2,
        CASE_CLAMP  = 2'd3
    } case_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_DIV,
        S_START,
        S_LANE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/kvi_if.sv
// ----------------------------------------------------------------------------
// kvi_if: request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  track;
    logic [5:0]  key_slot;
    logic [6:0]  key_total;
    logic [31:0] key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [31:0] sample_time;

    modport source (output valid, operation, track, key_slot, key_total, key_time,
                    value_x, value_y, value_z, sample_time, input ready);
    modport sink   (input valid, operation, track, key_slot, key_total, key_time,
                    value_x, value_y, value_z, sample_time, output ready);
endinterface

interface kvi_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]  segment_start;
    logic [1:0]  sample_case;

    modport source (output valid, out_x, out_y, out_z, segment_start, sample_case,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, segment_start, sample_case,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/kvi_div.sv
// ----------------------------------------------------------------------------
// kvi_div: segment fraction divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den
// with num < den, so the quotient fits in FRAC_BITS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kvi_div #(
    parameter int FRAC_BITS = kvi_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [31:0]          num,
    input  wire logic [31:0]          den,
    output logic                      done,
    output logic [FRAC_BITS-1:0]      quot
);

    localparam int CNTW = $clog2(FRAC_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [32:0]          shifted;
    logic [32:0]          trial;
    logic                 fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[31:0] : shifted[31:0];
            q_reg   <= {q_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// File: hdl/kvi_lane.sv
// ----------------------------------------------------------------------------
// kvi_lane: one vector component lane
// Holds the key table of one component, reads both segment keys and
// computes a + floor((b - a) * frac / 2^FRAC_BITS), saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module kvi_lane #(
    parameter int AW        = 10,
    parameter int FRAC_BITS = kvi_pkg::DEF_FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [31:0]           wr_data,
    input  wire logic                  start,
    input  wire logic [AW-1:0]         rd_a,
    input  wire logic [AW-1:0]         rd_b,
    input  wire logic [FRAC_BITS-1:0]  frac,
    output logic                       done,
    output logic signed [31:0]         result
);

    localparam int DEPTH = 1 << AW;
    localparam int PW    = 34 + FRAC_BITS;

    logic [31:0]          mem [DEPTH];
    logic [31:0]          rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [31:0]   a_reg;
    logic signed [32:0]   diff_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] sum;

    assign rd_addr = v1_reg ? rd_b : rd_a;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            a_reg <= $signed(rd_data_reg);
        if (v2_reg)
            diff_reg <= $signed({rd_data_reg[31], rd_data_reg}) - $signed({a_reg[31], a_reg});
        if (v3_reg)
            prod_reg <= PW'(diff_reg * $signed({1'b0, frac}));
    end

    // arithmetic shift is the floor of the scaled product
    assign sum = PW'(a_reg) + (prod_reg >>> FRAC_BITS);

    always_comb
    begin
        if (sum > PW'(32'sh7FFF_FFFF))
            result = 32'sh7FFF_FFFF;
        else if (sum < -PW'(33'sh0_8000_0000))
            result = 32'sh8000_0000;
        else
            result = sum[31:0];
    end

    // prod_reg holds from the cycle after v3 until the next start
    logic v4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    assign done = v4_reg;

endmodule

`default_nettype wire

// File: hdl/keyframe_vector_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator: keyframe track sampler
// Stores keyframe tracks and linearly interpolates a 3-vector at a time.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on req; operation selects a key write, a
// key count update or a sample. Only a sample returns a beat on rsp.
// A sample walks the track's times in the time table key by key (address,
// then compare), runs the serial fraction divider when the sample lies in
// an interpolated segment with ordered times, then the three component
// lanes (read a, read b, subtract, multiply), and loads the output register
// once it is free; a sample of an empty track goes straight to the output.
// One sample is in flight at a time.
// track_kind is to be written through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this.
// Reset clears key counts, track_kind and the handshake state; key tables
// are not cleared and must be written before a track uses them.
// A result waits in the output register while rsp.ready is low; the next
// request is still taken and held back only when its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_interpolator #(
    parameter int MAX_TRACKS = kvi_pkg::DEF_MAX_TRACKS,
    parameter int MAX_KEYS   = kvi_pkg::DEF_MAX_KEYS,
    parameter int FRAC_BITS  = kvi_pkg::DEF_FRAC_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    kvi_req_if.sink     req,
    kvi_rsp_if.source   rsp
);

    localparam int DEPTH = MAX_TRACKS * MAX_KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    kvi_pkg::state_t state_reg, state_next;

    logic                  kind_reg;
    logic [CW-1:0]         count_reg [MAX_TRACKS];
    logic [31:0]           time_mem [DEPTH];
    logic [31:0]           time_rd_reg;

    logic [31:0]           t_reg;
    logic [31:0]           tprev_reg;
    logic [CW-1:0]         n_reg;
    logic [KW-1:0]         idx_reg;
    logic [AW-1:0]         base_reg;
    logic [AW-1:0]         a_reg;
    logic                  lerp_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [KW-1:0]         seg_reg;
    kvi_pkg::case_t        case_reg;

    logic                  out_valid_reg;
    logic signed [31:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [5:0]            out_seg_reg;
    kvi_pkg::case_t        out_case_reg;

    logic                  accept;
    logic                  trk_ok, slot_ok;
    logic [31:0]           trk_ext, slot_ext, seg_ext;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  key_wr;
    logic                  is_last;
    logic                  below;
    logic                  div_ok;
    logic                  lane_start, div_start;
    logic                  out_load;
    logic                  lane_done_x, lane_done_y, lane_done_z;
    logic signed [31:0]    lane_x, lane_y, lane_z;
    logic                  div_done;
    logic [FRAC_BITS-1:0]  div_quot;
    logic [31:0]           dflt;

    assign accept   = req.valid && req.ready;
    assign trk_ext  = 32'(req.track);
    assign slot_ext = 32'(req.key_slot);
    assign trk_ok   = trk_ext < MAX_TRACKS;
    assign slot_ok  = slot_ext < MAX_KEYS;
    assign wr_addr  = AW'(trk_ext * MAX_KEYS + slot_ext);
    assign key_wr   = accept && (req.operation == kvi_pkg::OP_WRITE_KEY) && trk_ok && slot_ok;
    assign rd_addr  = base_reg + AW'(idx_reg);
    assign is_last  = (32'(idx_reg) + 32'd1) == 32'(n_reg);
    assign below    = t_reg < time_rd_reg;
    assign div_ok   = (t_reg >= tprev_reg) && (time_rd_reg > tprev_reg);
    assign seg_ext  = 32'(seg_reg);
    assign dflt     = kind_reg ? (32'd1 << FRAC_BITS) : 32'd0;
    assign out_load = (state_reg == kvi_pkg::S_DONE) && (!out_valid_reg || rsp.ready);

    // configuration and key counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            for (int i = 0; i < MAX_TRACKS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                kind_reg <= cfg_wr_data;
            if (accept && (req.operation == kvi_pkg::OP_SET_COUNT) && trk_ok)
            begin
                if (32'(req.key_total) > MAX_KEYS)
                    count_reg[trk_ext[TW-1:0]] <= CW'(MAX_KEYS);
                else
                    count_reg[trk_ext[TW-1:0]] <= CW'(req.key_total);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
            time_mem[wr_addr] <= req.key_time;
        time_rd_reg <= time_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvi_pkg::S_IDLE:
            begin
                if (accept && (req.operation == kvi_pkg::OP_SAMPLE))
                begin
                    if (trk_ok && (count_reg[trk_ext[TW-1:0]] != '0))
                        state_next = kvi_pkg::S_READ;
                    else
                        state_next = kvi_pkg::S_DONE;
                end
            end
            kvi_pkg::S_READ:  state_next = kvi_pkg::S_TEST;
            kvi_pkg::S_TEST:
            begin
                if (idx_reg == '0)
                begin
                    if (is_last || below)
                        state_next = kvi_pkg::S_START;
                    else
                        state_next = kvi_pkg::S_READ;
                end
                else if (below)
                    state_next = div_ok ? kvi_pkg::S_DIV : kvi_pkg::S_START;
                else if (is_last)
                    state_next = kvi_pkg::S_START;
                else
                    state_next = kvi_pkg::S_READ;
            end
            kvi_pkg::S_DIV:   if (div_done) state_next = kvi_pkg::S_START;
            kvi_pkg::S_START: state_next = kvi_pkg::S_LANE;
            kvi_pkg::S_LANE:  if (lane_done_x) state_next = kvi_pkg::S_DONE;
            kvi_pkg::S_DONE:  if (out_load) state_next = kvi_pkg::S_IDLE;
            default:          state_next = kvi_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        req.ready  = 1'b0;
        lane_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            kvi_pkg::S_IDLE:  req.ready = 1'b1;
            kvi_pkg::S_TEST:  div_start = (idx_reg != '0) && below && div_ok;
            kvi_pkg::S_START: lane_start = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kvi_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // sample datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            kvi_pkg::S_IDLE:
            begin
                t_reg    <= req.sample_time;
                n_reg    <= count_reg[trk_ext[TW-1:0]];
                base_reg <= trk_ok ? AW'(trk_ext * MAX_KEYS) : '0;
                idx_reg  <= '0;
                seg_reg  <= '0;
                lerp_reg <= 1'b0;
                frac_reg <= '0;
                case_reg <= kvi_pkg::CASE_EMPTY;
            end
            kvi_pkg::S_TEST:
            begin
                tprev_reg <= time_rd_reg;
                if (idx_reg == '0)
                begin
                    a_reg    <= base_reg;
                    case_reg <= is_last ? kvi_pkg::CASE_SINGLE : kvi_pkg::CASE_CLAMP;
                    if (!is_last && !below)
                        idx_reg <= idx_reg + 1'b1;
                end
                else if (below)
                begin
                    a_reg    <= rd_addr - 1'b1;
                    seg_reg  <= idx_reg - 1'b1;
                    lerp_reg <= 1'b1;
                    case_reg <= kvi_pkg::CASE_INTERP;
                end
                else if (is_last)
                begin
                    a_reg    <= rd_addr;
                    seg_reg  <= idx_reg;
                    case_reg <= kvi_pkg::CASE_CLAMP;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            kvi_pkg::S_DIV:
                if (div_done)
                    frac_reg <= div_quot;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_seg_reg  <= seg_ext[5:0];
            out_case_reg <= case_reg;
            if (case_reg == kvi_pkg::CASE_EMPTY)
            begin
                out_x_reg <= $signed(dflt);
                out_y_reg <= $signed(dflt);
                out_z_reg <= $signed(dflt);
            end
            else
            begin
                out_x_reg <= lane_x;
                out_y_reg <= lane_y;
                out_z_reg <= lane_z;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_x         = out_x_reg;
    assign rsp.out_y         = out_y_reg;
    assign rsp.out_z         = out_z_reg;
    assign rsp.segment_start = out_seg_reg;
    assign rsp.sample_case   = out_case_reg;

    kvi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_reg - tprev_reg),
        .den   (time_rd_reg - tprev_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    kvi_lane #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (key_wr),
        .wr_addr (wr_addr),
        .wr_data (req.value_x),
        .start   (lane_start),
        .rd_a    (a_reg),
        .rd_b    (a_reg + AW'(lerp_reg)),
        .frac    (frac_reg),
        .done    (lane_done_x),
        .result  (lane_x)
    );

    kvi_lane #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (key_wr),
        .wr_addr (wr_addr),
        .wr_data (req.value_y),
        .start   (lane_start),
        .rd_a    (a_reg),
        .rd_b    (a_reg + AW'(lerp_reg)),
        .frac    (frac_reg),
        .done    (lane_done_y),
        .result  (lane_y)
    );

    kvi_lane #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (key_wr),
        .wr_addr (wr_addr),
        .wr_data (req.value_z),
        .start   (lane_start),
        .rd_a    (a_reg),
        .rd_b    (a_reg + AW'(lerp_reg)),
        .frac    (frac_reg),
        .done    (lane_done_z),
        .result  (lane_z)
    );

`ifndef SYNTHESIS
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done_x |-> (lane_done_y && lane_done_z && state_reg == kvi_pkg::S_LANE))
        else $error("lanes out of step or done outside lane phase");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == kvi_pkg::S_DIV)
        else $error("divider finished outside divide phase");

    a_empty_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.sample_case == kvi_pkg::CASE_EMPTY) |-> rsp.segment_start == 6'd0)
        else $error("empty result with nonzero segment");
`endif

endmodule

`default_nettype wire

// File: sim/keyframe_vector_interpolator_checker.sv
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator_checker: passive scoreboard
// Watches the request, response and register ports, keeps its own copy of
// the key tables, predicts every sample beat and compares the responses.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_interpolator_checker
    import kvi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data,
    kvi_req_if        req,
    kvi_rsp_if        rsp,
    output int        pending,
    output int        error_count
);

    localparam int KEYS  = DEF_MAX_KEYS;
    localparam int FBITS = DEF_FRAC_BITS;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         seg;
        case_t              kind;
    } sample_t;

    logic [31:0] key_times [0:DEF_MAX_TRACKS*KEYS-1];
    logic [31:0] key_x     [0:DEF_MAX_TRACKS*KEYS-1];
    logic [31:0] key_y     [0:DEF_MAX_TRACKS*KEYS-1];
    logic [31:0] key_z     [0:DEF_MAX_TRACKS*KEYS-1];
    logic [6:0]  key_count [0:DEF_MAX_TRACKS-1];
    logic        scale_mode;

    sample_t expected_samples[$];

    assign pending = expected_samples.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic [31:0] blend(input logic [31:0] a_bits,
                                          input logic [31:0] b_bits,
                                          input longint frac);
        longint a;
        longint b;
        longint r;
        a = longint'(signed'(a_bits));
        b = longint'(signed'(b_bits));
        // arithmetic shift floors toward minus infinity
        r = a + (((b - a) * frac) >>> FBITS);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic sample_t key_at(input int addr, input int seg, input case_t k);
        sample_t s;
        s.x    = key_x[addr];
        s.y    = key_y[addr];
        s.z    = key_z[addr];
        s.seg  = seg[5:0];
        s.kind = k;
        return s;
    endfunction

    function automatic sample_t predict_sample(input logic [3:0] tr, input logic [31:0] t);
        sample_t s;
        int      n;
        int      base;
        int      seg;
        bit      found;
        longint  frac;
        logic [31:0] t0;
        logic [31:0] t1;
        n    = key_count[tr];
        base = tr * KEYS;
        if (n == 0) begin
            s.x    = scale_mode ? (32'sd1 <<< FBITS) : 32'sd0;
            s.y    = s.x;
            s.z    = s.x;
            s.seg  = '0;
            s.kind = CASE_EMPTY;
            return s;
        end
        if (n == 1)
            return key_at(base, 0, CASE_SINGLE);
        if (t < key_times[base])
            return key_at(base, 0, CASE_CLAMP);
        found = 0;
        seg   = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (!found && t < key_times[base + i + 1]) begin
                seg   = i;
                found = 1;
            end
        end
        if (!found)
            return key_at(base + n - 1, n - 1, CASE_CLAMP);
        t0   = key_times[base + seg];
        t1   = key_times[base + seg + 1];
        frac = 0;
        if (t >= t0 && t1 > t0)
            frac = longint'((64'(t - t0) << FBITS) / 64'(t1 - t0));
        s.x    = blend(key_x[base + seg], key_x[base + seg + 1], frac);
        s.y    = blend(key_y[base + seg], key_y[base + seg + 1], frac);
        s.z    = blend(key_z[base + seg], key_z[base + seg + 1], frac);
        s.seg  = seg[5:0];
        s.kind = CASE_INTERP;
        return s;
    endfunction

    initial error_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_MAX_TRACKS; i++)
                key_count[i] = '0;
            scale_mode = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                scale_mode = cfg_wr_data;
            if (req.valid && req.ready)
            begin
                case (op_t'(req.operation))
                    OP_WRITE_KEY:
                    begin
                        key_times[req.track*KEYS + req.key_slot] = req.key_time;
                        key_x[req.track*KEYS + req.key_slot]     = req.value_x;
                        key_y[req.track*KEYS + req.key_slot]     = req.value_y;
                        key_z[req.track*KEYS + req.key_slot]     = req.value_z;
                    end
                    OP_SET_COUNT:
                        key_count[req.track] = (req.key_total > KEYS) ? 7'(KEYS)
                                                                      : req.key_total;
                    OP_SAMPLE:
                        expected_samples.push_back(predict_sample(req.track,
                                                                  req.sample_time));
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("response beat with no sample outstanding");
                else
                begin
                    sample_t e;
                    e = expected_samples.pop_front();
                    if (rsp.out_x !== e.x)
                        report_mismatch($sformatf("out_x %h, want %h", rsp.out_x, e.x));
                    if (rsp.out_y !== e.y)
                        report_mismatch($sformatf("out_y %h, want %h", rsp.out_y, e.y));
                    if (rsp.out_z !== e.z)
                        report_mismatch($sformatf("out_z %h, want %h", rsp.out_z, e.z));
                    if (rsp.segment_start !== e.seg)
                        report_mismatch($sformatf("segment_start %0d, want %0d",
                                                  rsp.segment_start, e.seg));
                    if (rsp.sample_case !== e.kind)
                        report_mismatch($sformatf("sample_case %0d, want %0d",
                                                  rsp.sample_case, e.kind));
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/keyframe_vector_interpolator_test.sv
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator_test: testbench top
// Loads keyframe tracks, samples them under several idle/stall mixes and
// both track kinds; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_interpolator_test;
    import kvi_pkg::*;

    localparam int KEYS       = DEF_MAX_KEYS;
    localparam int IDLE_LIMIT = 6000;
    localparam int PHASE_BEATS = 430;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   pending;
    int   error_count;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   hold_request;
    int   hold_left;
    int   quiet_cycles;
    int   beats_sent;

    // keys written so far per track (always slots 0..depth-1) and their times
    int          track_depth [0:DEF_MAX_TRACKS-1];
    logic [31:0] track_times [0:DEF_MAX_TRACKS-1][0:KEYS-1];

    kvi_req_if req_ch();
    kvi_rsp_if rsp_ch();

    keyframe_vector_interpolator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    keyframe_vector_interpolator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .pending     (pending),
        .error_count (error_count)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(input op_t op, input logic [3:0] tr, input logic [5:0] slot,
                             input logic [6:0] total, input logic [31:0] kt,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [31:0] st);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.track       <= tr;
        req_ch.key_slot    <= slot;
        req_ch.key_total   <= total;
        req_ch.key_time    <= kt;
        req_ch.value_x     <= vx;
        req_ch.value_y     <= vy;
        req_ch.value_z     <= vz;
        req_ch.sample_time <= st;
        do
            @(posedge clk);
        while (!req_ch.ready);
        beats_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(4 << 16)) - 32'(2 << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_key(input logic [3:0] tr, input int slot, input logic [31:0] kt,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
        send_beat(OP_WRITE_KEY, tr, 6'(slot), 7'($urandom), kt, vx, vy, vz, $urandom);
        track_times[tr][slot] = kt;
        if (slot + 1 > track_depth[tr])
            track_depth[tr] = slot + 1;
    endtask

    task automatic set_count(input logic [3:0] tr, input logic [6:0] total);
        send_beat(OP_SET_COUNT, tr, 6'($urandom), total, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic sample(input logic [3:0] tr, input logic [31:0] st);
        send_beat(OP_SAMPLE, tr, 6'($urandom), 7'($urandom), $urandom, $urandom,
                  $urandom, $urandom, st);
    endtask

    // writes keys 0..k-1 of a track, sets the count and samples it a few times
    task automatic load_and_sample(input logic [3:0] tr, input int k);
        logic [31:0] t;
        logic [31:0] st;
        int          j;
        bit          sorted;
        sorted = ($urandom_range(9) != 0);
        t = $urandom_range(1 << 20);
        if ($urandom_range(15) == 0)
            t = 32'hFFFF_0000;
        for (int i = 0; i < k; i++)
        begin
            if (!sorted)
                t = $urandom;
            write_key(tr, i, t, pick_value(), pick_value(), pick_value());
            case ($urandom_range(3))
                0: t = t + 32'($urandom_range(3));
                1: t = t + $urandom_range(1 << 24);
                default: t = t + $urandom_range(1 << 17);
            endcase
        end
        if (k == KEYS && $urandom_range(1))
            set_count(tr, 7'($urandom_range(127, KEYS)));
        else
            set_count(tr, 7'(k));
        repeat ($urandom_range(8, 2))
        begin
            j = $urandom_range(k - 1);
            case ($urandom_range(7))
                0: st = 32'h0;
                1: st = 32'hFFFF_FFFF;
                2: st = track_times[tr][j];
                3: st = track_times[tr][j] - 1;
                4: st = $urandom;
                default: st = track_times[tr][j] + $urandom_range(1 << 18);
            endcase
            sample(tr, st);
        end
    endtask

    // the last beat is withdrawn first so the block goes idle before the write
    task automatic settle_and_configure(input logic kind);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= kind;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input logic kind,
                                input bit with_hold);
        int stop_at;
        int k;
        int tr;
        settle_and_configure(kind);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at = beats_sent + PHASE_BEATS;
        while (beats_sent < stop_at)
        begin
            if (with_hold && beats_sent > stop_at - PHASE_BEATS / 2)
            begin
                hold_request = 400;
                with_hold    = 0;
            end
            tr = $urandom_range(DEF_MAX_TRACKS - 1);
            case ($urandom_range(19))
                0: k = KEYS;
                1: k = 1;
                default: k = $urandom_range(8, 2);
            endcase
            case ($urandom_range(9))
                0:
                    send_beat(OP_NONE, 4'($urandom), 6'($urandom), 7'($urandom), $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                1:
                begin
                    set_count(4'(tr), 7'($urandom_range(track_depth[tr])));
                    sample(4'(tr), $urandom);
                end
                2:
                    sample(4'(tr), $urandom);
                default:
                    load_and_sample(4'(tr), k);
            endcase
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        beats_sent   = 0;
        for (int i = 0; i < DEF_MAX_TRACKS; i++)
            track_depth[i] = 0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_NONE;
        req_ch.track       = '0;
        req_ch.key_slot    = '0;
        req_ch.key_total   = '0;
        req_ch.key_time    = '0;
        req_ch.value_x     = '0;
        req_ch.value_y     = '0;
        req_ch.value_z     = '0;
        req_ch.sample_time = '0;
        rsp_ch.ready       = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, clamps at both ends, exact key, interpolation, single key, no-op
        settle_and_configure(1'b0);
        sample(4'd0, 32'h0);
        write_key(4'd1, 0, 32'd100 << 16, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        write_key(4'd1, 1, 32'd200 << 16, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        write_key(4'd1, 2, 32'd300 << 16, 32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        set_count(4'd1, 7'd3);
        sample(4'd1, 32'd50 << 16);
        sample(4'd1, 32'd100 << 16);
        sample(4'd1, 32'd150 << 16);
        sample(4'd1, (32'd250 << 16) + 32'd12345);
        sample(4'd1, 32'd300 << 16);
        sample(4'd1, 32'hFFFF_FFFF);
        write_key(4'd2, 0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        set_count(4'd2, 7'd1);
        sample(4'd2, 32'h0);
        // times out of order
        write_key(4'd15, 0, 32'd500, 32'h0010_0000, 32'h0, 32'h0);
        write_key(4'd15, 1, 32'd100, 32'h0020_0000, 32'h0, 32'h0);
        write_key(4'd15, 2, 32'd900, 32'hFFF0_0000, 32'h0, 32'h0);
        set_count(4'd15, 7'd3);
        sample(4'd15, 32'd600);
        send_beat(OP_NONE, 4'hF, 6'h3F, 7'h7F, '1, '1, '1, '1, '1);
        settle_and_configure(1'b1);
        sample(4'd0, 32'h1234);

        random_phase(0, 0, 1'b0, 1'b1);
        random_phase(74, 0, 1'b1, 1'b0);
        random_phase(0, 74, 1'b0, 1'b0);
        random_phase(30, 30, 1'b1, 1'b0);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
